// File: rtl/core/gbci_pkg.sv
// Shared widths, types, reset values and codes for the gyro bias
// calibration and rate integration block. No dependencies.
`timescale 1ns / 1ps

package gbci_pkg;

  // Field and register widths
  localparam int RATE_BITS  = 16;
  localparam int ANGLE_BITS = 48;
  localparam int DT_W       = 16;
  localparam int DZ_W       = 26;
  localparam int CAL_W      = 26;
  localparam int GATE_W     = 32;
  localparam int GAIN_W     = 18;
  localparam int CNT_W      = 32;
  localparam int SUM_W      = 64;
  localparam int DRIFT_W    = 40;
  localparam int Q_FRAC     = 16;
  localparam int PROD_SHIFT = 2 * Q_FRAC;

  // Derived datapath widths
  localparam int RSC_W   = RATE_BITS + Q_FRAC;
  localparam int DIFF_W  = ((RSC_W > DRIFT_W) ? RSC_W : DRIFT_W) + 1;
  localparam int DMAG_W  = RATE_BITS + DT_W;
  localparam int MA_W    = DIFF_W + DT_W;
  localparam int MB_W    = (GAIN_W > DT_W) ? GAIN_W : DT_W;
  localparam int MP_W    = MA_W + MB_W;
  localparam int TERM_W  = MP_W - PROD_SHIFT + 1;
  localparam int ASUM_W  = ((ANGLE_BITS > TERM_W) ? ANGLE_BITS : TERM_W) + 1;
  localparam int DIV_N_W = SUM_W - 1 + Q_FRAC;
  localparam int MUL_CNT_W = $clog2(MB_W + 1);
  localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

  // Port widths
  localparam int IN_W       = ((RATE_BITS + DT_W + 7) / 8) * 8;
  localparam int OUT_W      = ((ANGLE_BITS + 1 + 7) / 8) * 8;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CALTIME  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GATE     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 8'd3;

  // Configuration reset values
  localparam logic [DZ_W-1:0]   DZ_RST   = 26'd1000000;
  localparam logic [CAL_W-1:0]  CAL_RST  = 26'd5000000;
  localparam logic [GATE_W-1:0] GATE_RST = 32'd160000000;
  localparam logic [GAIN_W-1:0] GAIN_RST = 18'd65536;

  // Width types used for explicit extension
  typedef logic [MA_W-1:0]             mul_a_t;
  typedef logic [MB_W-1:0]             mul_b_t;
  typedef logic [MP_W-1:0]             mul_p_t;
  typedef logic [MUL_CNT_W-1:0]        mul_cnt_t;
  typedef logic [DIV_CNT_W-1:0]        div_cnt_t;
  typedef logic [DIV_N_W-1:0]          div_n_t;
  typedef logic [CNT_W-1:0]            cnt_t;
  typedef logic [CNT_W:0]              cnt_x_t;
  typedef logic [SUM_W-1:0]            sum_t;
  typedef logic signed [SUM_W:0]       sum_x_t;
  typedef logic signed [DRIFT_W-1:0]   drift_t;
  typedef logic [DRIFT_W-2:0]          dmag_t;
  typedef logic signed [ASUM_W-1:0]    asum_t;
  typedef logic [OUT_W-1:0]            out_t;

  typedef enum logic [1:0] {
    PH_DEAD = 2'd0,
    PH_CAL  = 2'd1,
    PH_RUN  = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_CAL_MUL,
    ST_DIV_START,
    ST_DIV,
    ST_RUN_MUL1,
    ST_RUN_MUL2,
    ST_DONE
  } state_e;

  // Shared multiplier request and response
  typedef struct packed {
    logic   start;
    mul_a_t a;
    mul_b_t b;
  } mul_req_t;

  typedef struct packed {
    logic   done;
    mul_p_t p;
  } mul_rsp_t;

  // Drift divider request and response
  typedef struct packed {
    logic   start;
    div_n_t dividend;
    cnt_t   divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    dmag_t mag;
  } div_rsp_t;

endpackage

// File: rtl/core/gbci_mul.sv
// Iterative unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on gbci_pkg for widths and the request/response structs.
`timescale 1ns / 1ps

module gbci_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gbci_pkg::mul_req_t req_i,
  output gbci_pkg::mul_rsp_t rsp_o
);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  gbci_pkg::mul_cnt_t  cnt_q, cnt_d;
  gbci_pkg::mul_p_t    acc_q, acc_d;
  gbci_pkg::mul_p_t    a_q, a_d;
  gbci_pkg::mul_b_t    b_q, b_d;

  // Load on start, then add the shifted multiplicand for each set bit.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = gbci_pkg::mul_cnt_t'(gbci_pkg::MB_W);
      acc_d  = '0;
      a_d    = gbci_pkg::mul_p_t'(req_i.a);
      b_d    = req_i.b;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_d = acc_q + a_q;
      end
      a_d   = a_q << 1;
      b_d   = b_q >> 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == gbci_pkg::mul_cnt_t'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.p    = acc_q;

endmodule

// File: rtl/core/gbci_div.sv
// Restoring divider for the drift rate, one quotient bit per cycle, with
// saturation of the quotient magnitude. Depends on gbci_pkg.
`timescale 1ns / 1ps

module gbci_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gbci_pkg::div_req_t req_i,
  output gbci_pkg::div_rsp_t rsp_o
);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  gbci_pkg::div_cnt_t  cnt_q, cnt_d;
  gbci_pkg::div_n_t    n_q, n_d;
  gbci_pkg::cnt_t      d_q, d_d;
  gbci_pkg::cnt_t      r_q, r_d;
  gbci_pkg::drift_t    q_q, q_d;
  logic                ovf_q, ovf_d;
  gbci_pkg::cnt_x_t    r_sh;
  logic                ge;
  logic                sat;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    r_sh   = {r_q, n_q[gbci_pkg::DIV_N_W-1]};
    ge     = (r_sh >= {1'b0, d_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    n_d    = n_q;
    d_d    = d_q;
    r_d    = r_q;
    q_d    = q_q;
    ovf_d  = ovf_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = gbci_pkg::div_cnt_t'(gbci_pkg::DIV_N_W);
      n_d    = req_i.dividend;
      d_d    = req_i.divisor;
      r_d    = '0;
      q_d    = '0;
      ovf_d  = 1'b0;
    end else if (busy_q) begin
      n_d   = n_q << 1;
      r_d   = ge ? gbci_pkg::cnt_t'(r_sh - {1'b0, d_q}) : r_sh[gbci_pkg::CNT_W-1:0];
      q_d   = {q_q[gbci_pkg::DRIFT_W-2:0], ge};
      ovf_d = ovf_q | q_q[gbci_pkg::DRIFT_W-1];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == gbci_pkg::div_cnt_t'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    d_q   <= d_d;
    r_q   <= r_d;
    q_q   <= q_d;
    ovf_q <= ovf_d;
  end

  // Any quotient bit at or above the sign position saturates the drift.
  assign sat        = ovf_q | q_q[gbci_pkg::DRIFT_W-1];
  assign rsp_o.done = done_q;
  assign rsp_o.mag  = sat ? '1 : q_q[gbci_pkg::DRIFT_W-2:0];

endmodule

// File: rtl/core/gyro_bias_calibrate_integrate.sv
// Gyro bias calibration and rate integration, top level with sequencer.
// Per item: a dead-zone item only updates the elapsed time; a calibration item does one
// 18-step multiply; the item that ends calibration adds a 79-step divide unless the gated
// time is zero; a running item does two 18-step multiplies on the shared multiplier. The
// next item is accepted once the result is in the output register, even while it waits there.
// Reset (rst_ni low, asynchronous) resets the control and architectural state and loads the register defaults.
`timescale 1ns / 1ps

module gyro_bias_calibrate_integrate (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [gbci_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gbci_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Input items
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata fields from bit 0: rate, dt_us
  input  logic [gbci_pkg::IN_W-1:0]       s_axis_tdata,
  // Result items
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata fields from bit 0: angle, led_on
  output logic [gbci_pkg::OUT_W-1:0]      m_axis_tdata,
  // tuser fields from bit 0: calibrated
  output logic                            m_axis_tuser
);

  localparam gbci_pkg::sum_x_t SUM_MAX_X =
      {2'b00, {(gbci_pkg::SUM_W - 1){1'b1}}};
  localparam gbci_pkg::sum_x_t SUM_MIN_X = -SUM_MAX_X;
  localparam gbci_pkg::asum_t ANG_MAX_X =
      {{(gbci_pkg::ASUM_W - gbci_pkg::ANGLE_BITS + 1){1'b0}},
       {(gbci_pkg::ANGLE_BITS - 1){1'b1}}};
  localparam gbci_pkg::asum_t ANG_MIN_X = -ANG_MAX_X - 1;

  gbci_pkg::state_e state_q, state_d;
  gbci_pkg::phase_e phase_q, phase_d;

  logic [gbci_pkg::DZ_W-1:0]   dz_q, dz_d;
  logic [gbci_pkg::CAL_W-1:0]  cal_q, cal_d;
  logic [gbci_pkg::GATE_W-1:0] gate_q, gate_d;
  logic [gbci_pkg::GAIN_W-1:0] gain_q, gain_d;

  gbci_pkg::cnt_t   elapsed_q, elapsed_d;
  gbci_pkg::cnt_t   gated_q, gated_d;
  gbci_pkg::sum_t   drift_sum_q, drift_sum_d;
  gbci_pkg::drift_t drift_q, drift_d;
  logic signed [gbci_pkg::ANGLE_BITS-1:0] angle_q, angle_d;
  logic             led_q, led_d;

  logic signed [gbci_pkg::RATE_BITS-1:0] rate_q, rate_d;
  logic [gbci_pkg::DT_W-1:0]             dt_q, dt_d;
  logic                                  diff_neg_q, diff_neg_d;

  logic                                   out_valid_q, out_valid_d;
  logic signed [gbci_pkg::ANGLE_BITS-1:0] out_angle_q, out_angle_d;
  logic                                   out_cal_q, out_cal_d;
  logic                                   out_led_q, out_led_d;

  gbci_pkg::mul_req_t mul_req;
  gbci_pkg::mul_rsp_t mul_rsp;
  gbci_pkg::div_req_t div_req;
  gbci_pkg::div_rsp_t div_rsp;

  // Datapath terms
  gbci_pkg::cnt_x_t                   elapsed_full, gated_full;
  gbci_pkg::cnt_t                     elapsed_sum, gated_sum;
  logic [gbci_pkg::RATE_BITS-1:0]     rate_mag;
  logic signed [gbci_pkg::DIFF_W-1:0] rate_sc, drift_x, diff;
  logic [gbci_pkg::DIFF_W-1:0]        diff_mag;
  logic [gbci_pkg::DMAG_W-1:0]        delta_mag;
  logic                               gate_fail;
  gbci_pkg::sum_x_t                   dm_x, delta_s, sum_x, sum_new;
  gbci_pkg::sum_t                     sum_sat, drift_mag;
  gbci_pkg::drift_t                   dq_x;
  logic [gbci_pkg::MP_W-gbci_pkg::PROD_SHIFT-1:0] u_mag;
  gbci_pkg::asum_t                    u_x, term_x, angle_x, angle_new;
  logic signed [gbci_pkg::ANGLE_BITS-1:0] angle_sat;

  gbci_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  gbci_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Saturating time counters.
  always_comb begin
    elapsed_full = {1'b0, elapsed_q} + gbci_pkg::cnt_x_t'(dt_q);
    elapsed_sum  = elapsed_full[gbci_pkg::CNT_W] ? '1 : elapsed_full[gbci_pkg::CNT_W-1:0];
    gated_full   = {1'b0, gated_q} + gbci_pkg::cnt_x_t'(dt_q);
    gated_sum    = gated_full[gbci_pkg::CNT_W] ? '1 : gated_full[gbci_pkg::CNT_W-1:0];
  end

  // Magnitudes of the rate and of the drift-corrected Q16 rate.
  always_comb begin
    rate_mag = rate_q[gbci_pkg::RATE_BITS-1] ? (~rate_q + 1'b1) : rate_q;
    rate_sc  = {{(gbci_pkg::DIFF_W - gbci_pkg::RSC_W){rate_q[gbci_pkg::RATE_BITS-1]}},
                rate_q, {gbci_pkg::Q_FRAC{1'b0}}};
    drift_x  = {{(gbci_pkg::DIFF_W - gbci_pkg::DRIFT_W){drift_q[gbci_pkg::DRIFT_W-1]}},
                drift_q};
    diff     = rate_sc - drift_x;
    diff_mag = diff[gbci_pkg::DIFF_W-1] ? (~diff + 1'b1) : diff;
  end

  // Gate check and saturating accumulation of the calibration step.
  always_comb begin
    delta_mag = mul_rsp.p[gbci_pkg::DMAG_W-1:0];
    gate_fail = (gbci_pkg::sum_t'(delta_mag) >= gbci_pkg::sum_t'(gate_q));
    dm_x      = gbci_pkg::sum_x_t'(delta_mag);
    delta_s   = rate_q[gbci_pkg::RATE_BITS-1] ? -dm_x : dm_x;
    sum_x     = {drift_sum_q[gbci_pkg::SUM_W-1], drift_sum_q};
    sum_new   = sum_x + delta_s;
    if (sum_new > SUM_MAX_X) begin
      sum_sat = SUM_MAX_X[gbci_pkg::SUM_W-1:0];
    end else if (sum_new < SUM_MIN_X) begin
      sum_sat = SUM_MIN_X[gbci_pkg::SUM_W-1:0];
    end else begin
      sum_sat = sum_new[gbci_pkg::SUM_W-1:0];
    end
    drift_mag = drift_sum_q[gbci_pkg::SUM_W-1] ? (~drift_sum_q + 1'b1) : drift_sum_q;
    dq_x      = {1'b0, div_rsp.mag};
  end

  // Scaled running increment and saturating angle.
  always_comb begin
    u_mag     = mul_rsp.p[gbci_pkg::MP_W-1:gbci_pkg::PROD_SHIFT];
    u_x       = gbci_pkg::asum_t'(u_mag);
    term_x    = diff_neg_q ? -u_x : u_x;
    angle_x   = {{(gbci_pkg::ASUM_W - gbci_pkg::ANGLE_BITS){angle_q[gbci_pkg::ANGLE_BITS-1]}},
                 angle_q};
    angle_new = angle_x + term_x;
    if (angle_new > ANG_MAX_X) begin
      angle_sat = ANG_MAX_X[gbci_pkg::ANGLE_BITS-1:0];
    end else if (angle_new < ANG_MIN_X) begin
      angle_sat = ANG_MIN_X[gbci_pkg::ANGLE_BITS-1:0];
    end else begin
      angle_sat = angle_new[gbci_pkg::ANGLE_BITS-1:0];
    end
  end

  // Sequencer: next state, register writes and unit requests.
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    dz_d        = dz_q;
    cal_d       = cal_q;
    gate_d      = gate_q;
    gain_d      = gain_q;
    elapsed_d   = elapsed_q;
    gated_d     = gated_q;
    drift_sum_d = drift_sum_q;
    drift_d     = drift_q;
    angle_d     = angle_q;
    led_d       = led_q;
    rate_d      = rate_q;
    dt_d        = dt_q;
    diff_neg_d  = diff_neg_q;
    out_valid_d = out_valid_q;
    out_angle_d = out_angle_q;
    out_cal_d   = out_cal_q;
    out_led_d   = out_led_q;
    mul_req     = '0;
    div_req     = '0;

    // Configuration writes; unknown indexes are dropped.
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        gbci_pkg::REG_DEADZONE: dz_d   = cfg_data_i[gbci_pkg::DZ_W-1:0];
        gbci_pkg::REG_CALTIME:  cal_d  = cfg_data_i[gbci_pkg::CAL_W-1:0];
        gbci_pkg::REG_GATE:     gate_d = cfg_data_i[gbci_pkg::GATE_W-1:0];
        gbci_pkg::REG_GAIN:     gain_d = cfg_data_i[gbci_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      gbci_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          rate_d  = s_axis_tdata[gbci_pkg::RATE_BITS-1:0];
          dt_d    = s_axis_tdata[gbci_pkg::RATE_BITS +: gbci_pkg::DT_W];
          state_d = gbci_pkg::ST_DISPATCH;
        end
      end
      gbci_pkg::ST_DISPATCH: begin
        if (phase_q == gbci_pkg::PH_RUN) begin
          mul_req.start = 1'b1;
          mul_req.a     = gbci_pkg::mul_a_t'(diff_mag);
          mul_req.b     = gbci_pkg::mul_b_t'(dt_q);
          diff_neg_d    = diff[gbci_pkg::DIFF_W-1];
          state_d       = gbci_pkg::ST_RUN_MUL1;
        end else if (gbci_pkg::cnt_t'(dz_q) > elapsed_q) begin
          phase_d   = gbci_pkg::PH_DEAD;
          elapsed_d = elapsed_sum;
          state_d   = gbci_pkg::ST_DONE;
        end else begin
          mul_req.start = 1'b1;
          mul_req.a     = gbci_pkg::mul_a_t'(rate_mag);
          mul_req.b     = gbci_pkg::mul_b_t'(dt_q);
          state_d       = gbci_pkg::ST_CAL_MUL;
        end
      end
      gbci_pkg::ST_CAL_MUL: begin
        if (mul_rsp.done) begin
          phase_d = gbci_pkg::PH_CAL;
          state_d = gbci_pkg::ST_DONE;
          if (!gate_fail) begin
            drift_sum_d = sum_sat;
            gated_d     = gated_sum;
            if (gated_sum >= gbci_pkg::cnt_t'(cal_q)) begin
              if (gated_sum == '0) begin
                // Zero gated time gives zero drift.
                drift_d = '0;
                phase_d = gbci_pkg::PH_RUN;
              end else begin
                state_d = gbci_pkg::ST_DIV_START;
              end
            end
          end
        end
      end
      gbci_pkg::ST_DIV_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = {drift_mag[gbci_pkg::SUM_W-2:0], {gbci_pkg::Q_FRAC{1'b0}}};
        div_req.divisor  = gated_q;
        state_d          = gbci_pkg::ST_DIV;
      end
      gbci_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          drift_d = drift_sum_q[gbci_pkg::SUM_W-1] ? -dq_x : dq_x;
          phase_d = gbci_pkg::PH_RUN;
          state_d = gbci_pkg::ST_DONE;
        end
      end
      gbci_pkg::ST_RUN_MUL1: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = mul_rsp.p[gbci_pkg::MA_W-1:0];
          mul_req.b     = gbci_pkg::mul_b_t'(gain_q);
          state_d       = gbci_pkg::ST_RUN_MUL2;
        end
      end
      gbci_pkg::ST_RUN_MUL2: begin
        if (mul_rsp.done) begin
          angle_d = angle_sat;
          led_d   = 1'b0;
          state_d = gbci_pkg::ST_DONE;
        end
      end
      gbci_pkg::ST_DONE: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_angle_d = angle_q;
          out_cal_d   = (phase_q == gbci_pkg::PH_RUN);
          out_led_d   = led_q;
          state_d     = gbci_pkg::ST_IDLE;
        end
      end
      default: state_d = gbci_pkg::ST_IDLE;
    endcase
  end

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gbci_pkg::ST_IDLE;
      phase_q     <= gbci_pkg::PH_DEAD;
      dz_q        <= gbci_pkg::DZ_RST;
      cal_q       <= gbci_pkg::CAL_RST;
      gate_q      <= gbci_pkg::GATE_RST;
      gain_q      <= gbci_pkg::GAIN_RST;
      elapsed_q   <= '0;
      gated_q     <= '0;
      drift_sum_q <= '0;
      drift_q     <= '0;
      angle_q     <= '0;
      led_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      dz_q        <= dz_d;
      cal_q       <= cal_d;
      gate_q      <= gate_d;
      gain_q      <= gain_d;
      elapsed_q   <= elapsed_d;
      gated_q     <= gated_d;
      drift_sum_q <= drift_sum_d;
      drift_q     <= drift_d;
      angle_q     <= angle_d;
      led_q       <= led_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Item and result payload.
  always_ff @(posedge clk_i) begin
    rate_q      <= rate_d;
    dt_q        <= dt_d;
    diff_neg_q  <= diff_neg_d;
    out_angle_q <= out_angle_d;
    out_cal_q   <= out_cal_d;
    out_led_q   <= out_led_d;
  end

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == gbci_pkg::ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = gbci_pkg::out_t'({out_led_q, out_angle_q});
  assign m_axis_tuser  = out_cal_q;

endmodule
